@@ rtl/nwt_pkg.sv @@
package nwt_pkg;

  typedef struct packed {
    logic signed [31:0] number;
    logic               mode;
  } in_t;

  typedef struct packed {
    logic [6:0] word_code;
    logic       last_word;
  } out_t;

  // decoded item handed from front to back
  typedef struct packed {
    logic            neg;
    logic            alot;
    logic            ord;
    logic [9:0][3:0] dig;
  } rec_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } front_state_t;

  localparam logic [6:0] TOK_TWENTY   = 7'd20;
  localparam logic [6:0] TOK_HUNDRED  = 7'd56;
  localparam logic [6:0] TOK_THOUSAND = 7'd57;
  localparam logic [6:0] TOK_MILLION  = 7'd58;
  localparam logic [6:0] TOK_BILLION  = 7'd59;
  localparam logic [6:0] TOK_AND      = 7'd64;
  localparam logic [6:0] TOK_MINUS    = 7'd65;
  localparam logic [6:0] TOK_A_LOT    = 7'd66;
  localparam logic [6:0] ORD_OFS      = 7'd28;
  localparam logic [6:0] SCALE_OFS    = 7'd4;

  localparam int NPH = 26;  // minus, a lot, 4 groups x 6 slots
  localparam logic [4:0] CONV_STEPS = 5'd16;

endpackage

@@ rtl/nwt_front.sv @@
module nwt_front (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  nwt_pkg::in_t in_data,
  output logic         push,
  input  logic         full,
  output nwt_pkg::rec_t rec
);

  nwt_pkg::front_state_t st_r, st_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] sh_r, sh_nxt;
  logic [39:0] bcd_r, bcd_nxt;
  logic        neg_r, neg_nxt, alot_r, alot_nxt, ord_r, ord_nxt;

  // one shift-add-3 step
  function automatic logic [39:0] dabble(input logic [39:0] b, input logic bit_in);
    logic [39:0] a;
    a = b;
    for (int i = 0; i < 10; i++) begin
      if (a[4*i +: 4] >= 4'd5) a[4*i +: 4] = a[4*i +: 4] + 4'd3;
    end
    return {a[38:0], bit_in};
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= nwt_pkg::F_IDLE;
      cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
    end
    sh_r <= sh_nxt;
    bcd_r <= bcd_nxt;
    neg_r <= neg_nxt;
    alot_r <= alot_nxt;
    ord_r <= ord_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    sh_nxt = sh_r;
    bcd_nxt = bcd_r;
    neg_nxt = neg_r;
    alot_nxt = alot_r;
    ord_nxt = ord_r;
    in_stall = (st_r != nwt_pkg::F_IDLE);
    push = 1'b0;
    case (st_r)
      nwt_pkg::F_IDLE: begin
        if (in_valid) begin
          neg_nxt = in_data.number[31];
          alot_nxt = (in_data.number == 32'sh8000_0000);
          ord_nxt = in_data.mode;
          sh_nxt = in_data.number[31] ? (~in_data.number + 32'd1) : in_data.number;
          bcd_nxt = '0;
          cnt_nxt = '0;
          st_nxt = nwt_pkg::F_CONV;
        end
      end
      nwt_pkg::F_CONV: begin
        bcd_nxt = dabble(dabble(bcd_r, sh_r[31]), sh_r[30]);
        sh_nxt = {sh_r[29:0], 2'b00};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == nwt_pkg::CONV_STEPS - 5'd1) st_nxt = nwt_pkg::F_PUSH;
      end
      nwt_pkg::F_PUSH: begin
        if (!full) begin
          push = 1'b1;
          st_nxt = nwt_pkg::F_IDLE;
        end
      end
      default: st_nxt = nwt_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    rec.neg = neg_r;
    rec.alot = alot_r;
    rec.ord = ord_r;
    for (int i = 0; i < 10; i++) rec.dig[i] = bcd_r[4*i +: 4];
  end

endmodule

@@ rtl/nwt_queue.sv @@
module nwt_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  nwt_pkg::rec_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output nwt_pkg::rec_t rdata
);

  nwt_pkg::rec_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) mem_r[wp_r] <= wdata;
  end

  assign full = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign rdata = mem_r[rp_r];

endmodule

@@ rtl/nwt_back.sv @@
module nwt_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  nwt_pkg::rec_t q_rec,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output nwt_pkg::out_t out_data
);

  nwt_pkg::rec_t rec_r;
  logic        busy_r;
  logic [4:0]  ph_r;
  logic        ov_r;
  nwt_pkg::out_t od_r;

  logic [nwt_pkg::NPH-1:0] emit;
  logic [6:0] tok [nwt_pkg::NPH];
  logic [4:0] ghv [4];
  logic [3:0] gt [4], go [4];
  logic [3:0] gz, rd, andg;
  logic       merge, usmall, allz;
  logic [nwt_pkg::NPH-1:0] later;
  logic       is_last, slot_free;
  logic [6:0] cur, fin;

  always_comb begin
    ghv[0] = '0;                 gt[0] = '0;           go[0] = rec_r.dig[9];
    ghv[1] = {1'b0, rec_r.dig[8]}; gt[1] = rec_r.dig[7]; go[1] = rec_r.dig[6];
    ghv[2] = {1'b0, rec_r.dig[5]}; gt[2] = rec_r.dig[4]; go[2] = rec_r.dig[3];
    merge = (rec_r.dig[5] == 4'd0) && (rec_r.dig[4] == 4'd0) && (rec_r.dig[3] == 4'd1)
            && (rec_r.dig[2] != 4'd0);
    // a thousands group of exactly one with a nonzero hundreds digit reads as eleven..nineteen hundred
    ghv[3] = merge ? (5'd10 + {1'b0, rec_r.dig[2]}) : {1'b0, rec_r.dig[2]};
    gt[3] = rec_r.dig[1];
    go[3] = rec_r.dig[0];
    for (int g = 0; g < 4; g++) gz[g] = (ghv[g] == 5'd0) && (gt[g] == 4'd0) && (go[g] == 4'd0);
    allz = &gz;
    usmall = (rec_r.dig[2] == 4'd0) && !((rec_r.dig[1] == 4'd0) && (rec_r.dig[0] == 4'd0));
    rd[0] = !gz[0] && !rec_r.alot;
    rd[1] = !gz[1] && !rec_r.alot;
    rd[2] = !gz[2] && !merge && !rec_r.alot;
    rd[3] = (!gz[3] || allz) && !rec_r.alot;
    andg[0] = rd[0] && gz[1] && gz[2] && usmall;
    andg[1] = rd[1] && gz[2] && usmall;
    andg[2] = rd[2] && usmall;
    andg[3] = 1'b0;

    emit[0] = rec_r.neg;  tok[0] = nwt_pkg::TOK_MINUS;
    emit[1] = rec_r.alot; tok[1] = nwt_pkg::TOK_A_LOT;
    for (int g = 0; g < 4; g++) begin
      emit[2+6*g] = rd[g] && (ghv[g] != 5'd0);
      tok[2+6*g]  = {2'b00, ghv[g]};
      emit[3+6*g] = rd[g] && (ghv[g] != 5'd0);
      tok[3+6*g]  = nwt_pkg::TOK_HUNDRED;
      emit[4+6*g] = rd[g] && (gt[g] >= 4'd2);
      tok[4+6*g]  = nwt_pkg::TOK_TWENTY - 7'd2 + {3'b000, gt[g]};
      emit[5+6*g] = rd[g] && ((gt[g] < 4'd2) ? ((gt[g] != 4'd0) || (go[g] != 4'd0)
                    || (ghv[g] == 5'd0)) : (go[g] != 4'd0));
      tok[5+6*g]  = (gt[g] == 4'd1) ? (7'd10 + {3'b000, go[g]}) : {3'b000, go[g]};
      emit[6+6*g] = rd[g] && (g != 3);
      tok[6+6*g]  = (g == 0) ? nwt_pkg::TOK_BILLION :
                    (g == 1) ? nwt_pkg::TOK_MILLION : nwt_pkg::TOK_THOUSAND;
      emit[7+6*g] = andg[g];
      tok[7+6*g]  = nwt_pkg::TOK_AND;
    end
  end

  always_comb begin
    later = emit >> ph_r;
    is_last = (later[nwt_pkg::NPH-1:1] == '0);
    cur = tok[ph_r];
    fin = cur;
    if (rec_r.ord && is_last) begin
      if (cur <= nwt_pkg::TOK_TWENTY + 7'd7) fin = cur + nwt_pkg::ORD_OFS;
      else if (cur >= nwt_pkg::TOK_HUNDRED && cur <= nwt_pkg::TOK_BILLION)
        fin = cur + nwt_pkg::SCALE_OFS;
    end
    slot_free = !ov_r || !out_stall;
    pop = !busy_r && q_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r <= '0;
      ov_r <= 1'b0;
    end else begin
      if (busy_r && emit[ph_r] && slot_free) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
      if (pop) begin
        busy_r <= 1'b1;
        ph_r <= '0;
      end else if (busy_r) begin
        if (emit[ph_r]) begin
          if (slot_free) begin
            if (is_last) busy_r <= 1'b0;
            else ph_r <= ph_r + 5'd1;
          end
        end else begin
          ph_r <= ph_r + 5'd1;
        end
      end
    end
    if (pop) rec_r <= q_rec;
    if (busy_r && emit[ph_r] && slot_free) begin
      od_r.word_code <= fin;
      od_r.last_word <= is_last;
    end
  end

  assign out_valid = ov_r;
  assign out_data = od_r;

endmodule

@@ rtl/number_to_word_tokens_unit.sv @@
// Number to English word tokens.
// Input channel: in_valid / in_stall / in_data (signed number, mode bit).
// An item is taken when in_valid is high and in_stall low.
// Output channel: out_valid / out_stall / out_data, one item per word,
// 1 to 17 words per number, last_word set on the final one.
// Front: accepts an item, converts the magnitude to ten decimal digits by
// shift-add-3, two bits a cycle, then pushes the result to the queue;
// in_stall is high from accept until the push, so no new item is taken before.
// A two-entry queue sits between front and back.
// Back: pops an item, then walks 26 word slots (minus, a lot, then per
// group hundreds digit, hundred, tens, ones, scale, and), one slot a cycle
// while no output word is stalled, up to the last slot that holds a word.
// Sustained rate is set by the slower of the two and by stalled output
// words.
// Reset (rst_n low, synchronous) empties queue and front/back control.
// A stalled output holds its word; the back waits, the queue fills and the
// front then holds in_stall high after its conversion until there is room.
module number_to_word_tokens_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  nwt_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output nwt_pkg::out_t out_data
);

  logic          push, full, q_valid, pop;
  nwt_pkg::rec_t f_rec, q_rec;

  nwt_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .push(push), .full(full), .rec(f_rec)
  );

  nwt_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(push), .wdata(f_rec), .full(full),
    .pop(pop), .valid(q_valid), .rdata(q_rec)
  );

  nwt_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_rec(q_rec), .pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule
